[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define TSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define TSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/tsr_pkg.sv]
// Types and constants of the byte stream reassembler
package tsr_pkg;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WIN_W      = 6;
  localparam int unsigned HELD_W     = 6;
  localparam int unsigned DEPTH_DEF  = 32;
  localparam int unsigned Q_DEPTH    = 2;
  localparam logic [WIN_W-1:0] WIN_RESET = 6'd32;

  // Result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]  stream_index;
    logic [BYTE_W-1:0] data_byte;
    logic              has_data;
    logic              end_of_stream;
  } tsr_in_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] out_byte;
    logic [POS_W-1:0]  out_position;
    logic [HELD_W-1:0] held_count;
    logic              stream_ended;
    logic              last;
  } tsr_out_t;

  // Segment record handed from the front to the back
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] data_byte;
    logic              has_data;
    logic              eos;
    logic [POS_W-1:0]  end_pos;
  } tsr_seg_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } tsr_qstat_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CLASS  = 7'b0000010,
    ST_INSERT = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_READ   = 7'b0010000,
    ST_EMIT   = 7'b0100000,
    ST_STATUS = 7'b1000000
  } tsr_state_e;

endpackage

[rtl/core/tsr_front.sv]
// Front end: accepts input transactions and builds segment records
module tsr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tsr_pkg::tsr_in_t  in_data_i,
  input  tsr_pkg::tsr_qstat_t qstat_i,
  output logic              push_o,
  output tsr_pkg::tsr_seg_t seg_o
);

  logic             full_q, full_d;
  tsr_pkg::tsr_in_t item_q;
  logic             take;

  // Hand the held item on whenever the queue has room
  assign push_o     = full_q && !qstat_i.full;
  assign in_stall_o = full_q && !push_o;
  assign take       = in_valid_i && !in_stall_o;

  // Work out the end position that an end mark would record
  always_comb begin
    seg_o.pos       = item_q.stream_index;
    seg_o.data_byte = item_q.data_byte;
    seg_o.has_data  = item_q.has_data;
    seg_o.eos       = item_q.end_of_stream;
    seg_o.end_pos   = item_q.has_data ? item_q.stream_index + tsr_pkg::POS_W'(1)
                                      : item_q.stream_index;
  end

  always_comb begin
    full_d = full_q;
    if (push_o) full_d = 1'b0;
    if (take)   full_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  // Capture the payload of an accepted transaction
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_data_i;
    end
  end

endmodule

[rtl/core/tsr_queue.sv]
// Short segment queue between the front and the back
module tsr_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tsr_pkg::tsr_seg_t   seg_i,
  input  logic                pop_i,
  output tsr_pkg::tsr_seg_t   seg_o,
  output tsr_pkg::tsr_qstat_t qstat_o
);

  localparam int unsigned PTR_W = $clog2(tsr_pkg::Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(tsr_pkg::Q_DEPTH + 1);

  tsr_pkg::tsr_seg_t  entry_q [tsr_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign qstat_o.full  = (count_q == CNT_W'(tsr_pkg::Q_DEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign seg_o         = entry_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(tsr_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(tsr_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store a pushed segment
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= seg_i;
    end
  end

endmodule

[rtl/core/tsr_back.sv]
// Back end: window check, byte ring, drain walk and result register
module tsr_back #(
  parameter int unsigned DEPTH = tsr_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tsr_pkg::WIN_W-1:0]  win_i,
  input  tsr_pkg::tsr_qstat_t        qstat_i,
  input  tsr_pkg::tsr_seg_t          seg_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output tsr_pkg::tsr_out_t          out_data_o
);

  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned POS_W  = tsr_pkg::POS_W;

  tsr_pkg::tsr_state_e state_q, state_d;

  logic [tsr_pkg::BYTE_W-1:0] ring_q [DEPTH];
  logic [tsr_pkg::BYTE_W-1:0] rd_data_q;
  logic [DEPTH-1:0]           valid_q, valid_d;

  logic [POS_W-1:0]           next_pos_q, next_pos_d;
  logic [SLOT_W-1:0]          next_slot_q, next_slot_d;
  logic [POS_W-1:0]           end_pos_q, end_pos_d;
  logic                       end_known_q, end_known_d;
  logic [tsr_pkg::HELD_W-1:0] held_q, held_d;

  tsr_pkg::tsr_seg_t          seg_q;
  logic                       behind_q, beyond_q;
  logic [SLOT_W-1:0]          slot_q;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [SLOT_W-1:0]          scan_slot_q, scan_slot_d;
  logic [POS_W-1:0]           scan_pos_q, scan_pos_d;
  logic                       ended_q, ended_d;

  logic                       out_valid_q, out_valid_d;
  tsr_pkg::tsr_out_t          out_q, out_d;

  logic [POS_W-1:0]           offset;
  logic                       behind, beyond;
  logic [SLOT_W:0]            slot_sum;
  logic [SLOT_W-1:0]          slot;
  logic                       out_free;
  logic                       do_store;
  logic [POS_W-1:0]           end_gap;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pop_o       = (state_q == tsr_pkg::ST_IDLE) && !qstat_i.empty;

  // Classify the segment against the window
  always_comb begin
    offset   = seg_q.pos - next_pos_q;
    behind   = offset[POS_W-1];
    beyond   = !behind && (offset >= {{(POS_W - tsr_pkg::WIN_W){1'b0}}, win_i});
    slot_sum = {1'b0, next_slot_q} + {1'b0, offset[SLOT_W-1:0]};
    slot     = (slot_sum >= (SLOT_W + 1)'(DEPTH)) ? SLOT_W'(slot_sum - (SLOT_W + 1)'(DEPTH))
                                                  : slot_sum[SLOT_W-1:0];
  end

  assign do_store = (state_q == tsr_pkg::ST_INSERT) && !beyond_q && seg_q.has_data &&
                    !behind_q && !valid_q[slot_q];
  assign end_gap  = scan_pos_q - end_pos_q;

  // Sequence one segment: classify, insert, scan the run, emit, report
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    next_pos_d  = next_pos_q;
    next_slot_d = next_slot_q;
    end_pos_d   = end_pos_q;
    end_known_d = end_known_q;
    held_d      = held_q;
    cnt_d       = cnt_q;
    scan_slot_d = scan_slot_q;
    scan_pos_d  = scan_pos_q;
    ended_d     = ended_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      tsr_pkg::ST_IDLE: begin
        if (!qstat_i.empty) state_d = tsr_pkg::ST_CLASS;
      end
      tsr_pkg::ST_CLASS: begin
        state_d = tsr_pkg::ST_INSERT;
      end
      tsr_pkg::ST_INSERT: begin
        if (do_store) begin
          valid_d[slot_q] = 1'b1;
          held_d          = held_q + 1'b1;
        end
        if (!beyond_q && seg_q.eos) begin
          end_pos_d   = seg_q.end_pos;
          end_known_d = 1'b1;
        end
        cnt_d       = '0;
        scan_slot_d = next_slot_q;
        scan_pos_d  = next_pos_q;
        state_d     = tsr_pkg::ST_SCAN;
      end
      tsr_pkg::ST_SCAN: begin
        // Count the contiguous run of stored bytes from the next position
        if ((cnt_q == CNT_W'(DEPTH)) || !valid_q[scan_slot_q]) begin
          ended_d = end_known_q && !end_gap[POS_W-1];
          state_d = (cnt_q == '0) ? tsr_pkg::ST_STATUS : tsr_pkg::ST_READ;
        end else begin
          cnt_d       = cnt_q + 1'b1;
          scan_slot_d = (scan_slot_q == SLOT_W'(DEPTH - 1)) ? '0 : scan_slot_q + 1'b1;
          scan_pos_d  = scan_pos_q + POS_W'(1);
        end
      end
      tsr_pkg::ST_READ: begin
        state_d = tsr_pkg::ST_EMIT;
      end
      tsr_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.kind           = tsr_pkg::KIND_BYTE;
          out_d.out_byte       = rd_data_q;
          out_d.out_position   = next_pos_q;
          out_d.held_count     = held_q - 1'b1;
          out_d.stream_ended   = ended_q;
          out_d.last           = 1'b0;
          valid_d[next_slot_q] = 1'b0;
          held_d               = held_q - 1'b1;
          next_pos_d           = next_pos_q + POS_W'(1);
          next_slot_d          = (next_slot_q == SLOT_W'(DEPTH - 1)) ? '0
                                                                    : next_slot_q + 1'b1;
          cnt_d                = cnt_q - 1'b1;
          state_d              = (cnt_q == CNT_W'(1)) ? tsr_pkg::ST_STATUS
                                                      : tsr_pkg::ST_READ;
        end
      end
      tsr_pkg::ST_STATUS: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.kind         = tsr_pkg::KIND_STATUS;
          out_d.out_byte     = '0;
          out_d.out_position = next_pos_q;
          out_d.held_count   = held_q;
          out_d.stream_ended = ended_q;
          out_d.last         = 1'b1;
          state_d            = tsr_pkg::ST_IDLE;
        end
      end
      default: state_d = tsr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsr_pkg::ST_IDLE;
      valid_q     <= '0;
      next_pos_q  <= '0;
      next_slot_q <= '0;
      end_pos_q   <= '0;
      end_known_q <= 1'b0;
      held_q      <= '0;
      cnt_q       <= '0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      next_pos_q  <= next_pos_d;
      next_slot_q <= next_slot_d;
      end_pos_q   <= end_pos_d;
      end_known_q <= end_known_d;
      held_q      <= held_d;
      cnt_q       <= cnt_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the segment, its classification, the scan cursor and the result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) seg_q <= seg_i;
    if (state_q == tsr_pkg::ST_CLASS) begin
      behind_q <= behind;
      beyond_q <= beyond;
      slot_q   <= slot;
    end
    scan_slot_q <= scan_slot_d;
    scan_pos_q  <= scan_pos_d;
    out_q       <= out_d;
  end

  // Byte ring: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (do_store) ring_q[slot_q] <= seg_q.data_byte;
    if (state_q == tsr_pkg::ST_READ) rd_data_q <= ring_q[next_slot_q];
  end

endmodule

[rtl/core/tcp_byte_stream_reassembler.sv]
// Top level of the byte stream reassembler
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------
//   in      | input     | in_valid / stall   | tsr_in_t  (one byte)
//   out     | output    | out_valid / stall  | tsr_out_t (byte/status)
//   cfg     | input     | cfg_valid / ready  | window_size, 6 bits
//
// In the back end an item is classified and inserted, then a scan walks the
// contiguous stored bytes, each byte gets a read and an emit step on the
// single ring read port, and a status result closes the item.
// Reset clears the valid map and all positions; the ring itself is not
// cleared and needs no sweep. The front register and a two-entry queue
// keep accepting while the back end waits on a stalled output.
module tcp_byte_stream_reassembler #(
  parameter int unsigned DEPTH = tsr_pkg::DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  tsr_pkg::tsr_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output tsr_pkg::tsr_out_t         out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tsr_pkg::WIN_W-1:0] cfg_data_i
);

  `include "assert_macros.svh"

  logic [tsr_pkg::WIN_W-1:0] win_q, win_eff;
  tsr_pkg::tsr_qstat_t       qstat;
  tsr_pkg::tsr_seg_t         push_seg, pop_seg;
  logic                      push, pop;

  // Window register; values above the ring depth act as the depth
  assign cfg_ready_o = 1'b1;
  assign win_eff     = (win_q > tsr_pkg::WIN_W'(DEPTH)) ? tsr_pkg::WIN_W'(DEPTH) : win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= tsr_pkg::WIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      win_q <= cfg_data_i;
    end
  end

  tsr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .seg_o      (push_seg)
  );

  tsr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .seg_i   (push_seg),
    .pop_i   (pop),
    .seg_o   (pop_seg),
    .qstat_o (qstat)
  );

  tsr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_i       (win_eff),
    .qstat_i     (qstat),
    .seg_i       (pop_seg),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Status results close an item and carry no byte
  `TSR_ASSERT_IMPL(a_status_last, out_valid_o && (out_data_o.kind == tsr_pkg::KIND_STATUS), out_data_o.last && (out_data_o.out_byte == '0), "status result without last or with a byte")
  // Byte results never close an item
  `TSR_ASSERT_IMPL(a_byte_not_last, out_valid_o && (out_data_o.kind == tsr_pkg::KIND_BYTE), !out_data_o.last, "byte result marked last")
  // Held count in a valid result never exceeds the ring depth
  `TSR_ASSERT(a_held_bound, !out_valid_o || (out_data_o.held_count <= tsr_pkg::HELD_W'(DEPTH)), "held count beyond ring depth")
  // Queue never reports full and empty together
  `TSR_ASSERT(a_queue_state, !(qstat.full && qstat.empty), "queue full and empty at once")

endmodule
